/* rtl/audio_level_meter_peak_hold_defines.svh */
// Assertion macros shared by the peak meter checker.
// Depends on nothing; included by almph_checker.sv.
`ifndef AUDIO_LEVEL_METER_PEAK_HOLD_DEFINES_SVH
`define AUDIO_LEVEL_METER_PEAK_HOLD_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define ALMPH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ALMPH_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* rtl/almph_pkg.sv */
// Package of the audio peak meter: widths, constants, FSM state, control structs.
// Depends on nothing.
package almph_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned CfgIdxW     = 8;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DEPTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_MASK  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_COEFF   = 8'd3;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;

  localparam logic [16:0] Q16_ONE       = 17'h10000;
  localparam logic [16:0] LEVEL_RESET   = 17'h08000;
  localparam logic [31:0] LOG10_2_HALF  = 32'd646456993;
  localparam logic [20:0] DROP_CAP      = 21'h100000;
  localparam logic [31:0] DECAY_RESET   = 32'd2814750;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP_UPD,
    ST_BLK_SCAN,
    ST_LOG_INIT,
    ST_SQ_MUL,
    ST_SQ_UPD,
    ST_LOG_MUL,
    ST_LOG_WR,
    ST_REF_SCAN,
    ST_REF_FIX,
    ST_REF_SQ,
    ST_REF_HI,
    ST_REF_LO,
    ST_REF_DROP,
    ST_REF_OUT
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic smp_upd;
    logic blk_skip;
    logic blk_end;
    logic log_init;
    logic sq_mul;
    logic sq_upd;
    logic log_mul;
    logic log_wr;
    logic ref_fix;
    logic ref_sq;
    logic ref_hi;
    logic ref_lo;
    logic ref_drop;
    logic ref_out;
  } cmd_t;

  typedef struct packed {
    logic is_refresh;
    logic is_last;
    logic scan_end;
    logic ch_shown;
    logic lvl_direct;
    logic iter_done;
    logic ref_end;
    logic out_free;
  } status_t;

endpackage

/* rtl/almph_if.sv */
// Handshake channels of the peak meter: input items, results, register writes.
// Depends on almph_pkg for the register index width.
interface almph_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] sample;
  logic        last_of_block;
  logic [31:0] time_now;
  modport source (output valid, req_type, sample, last_of_block, time_now, input ready);
  modport sink (input valid, req_type, sample, last_of_block, time_now, output ready);
endinterface

interface almph_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic [16:0] level;
  logic [16:0] held_peak;
  logic        last;
  modport source (output valid, channel, level, held_peak, last, input ready);
  modport sink (input valid, channel, level, held_peak, last, output ready);
endinterface

interface almph_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [almph_pkg::CfgIdxW-1:0] index;
  logic [31:0]                   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/almph_ctrl.sv */
// Controller of the peak meter: sequences sample updates, log conversion and refresh.
// Depends on almph_pkg.
module almph_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  almph_pkg::status_t st_i,
  output almph_pkg::cmd_t    cmd_o
);
  import almph_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_SMP_UPD;
        end
      end
      ST_SMP_UPD: begin
        if (st_i.is_refresh) begin
          state_d = ST_REF_SCAN;
        end else begin
          cmd_o.smp_upd = 1'b1;
          state_d = st_i.is_last ? ST_BLK_SCAN : ST_IDLE;
        end
      end
      ST_BLK_SCAN: begin
        if (st_i.scan_end) begin
          cmd_o.blk_end = 1'b1;
          state_d = ST_IDLE;
        end else if (st_i.ch_shown) begin
          state_d = ST_LOG_INIT;
        end else begin
          cmd_o.blk_skip = 1'b1;
        end
      end
      ST_LOG_INIT: begin
        cmd_o.log_init = 1'b1;
        state_d = st_i.lvl_direct ? ST_BLK_SCAN : ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d = ST_SQ_UPD;
      end
      ST_SQ_UPD: begin
        cmd_o.sq_upd = 1'b1;
        state_d = st_i.iter_done ? ST_LOG_MUL : ST_SQ_MUL;
      end
      ST_LOG_MUL: begin
        cmd_o.log_mul = 1'b1;
        state_d = ST_LOG_WR;
      end
      ST_LOG_WR: begin
        cmd_o.log_wr = 1'b1;
        state_d = ST_BLK_SCAN;
      end
      ST_REF_SCAN: begin
        state_d = st_i.ref_end ? ST_IDLE : ST_REF_FIX;
      end
      ST_REF_FIX: begin
        cmd_o.ref_fix = 1'b1;
        state_d = ST_REF_SQ;
      end
      ST_REF_SQ: begin
        cmd_o.ref_sq = 1'b1;
        state_d = ST_REF_HI;
      end
      ST_REF_HI: begin
        cmd_o.ref_hi = 1'b1;
        state_d = ST_REF_LO;
      end
      ST_REF_LO: begin
        cmd_o.ref_lo = 1'b1;
        state_d = ST_REF_DROP;
      end
      ST_REF_DROP: begin
        cmd_o.ref_drop = 1'b1;
        state_d = ST_REF_OUT;
      end
      ST_REF_OUT: begin
        // Hold here while the previous result still sits in the output register.
        if (st_i.out_free) begin
          cmd_o.ref_out = 1'b1;
          state_d = ST_REF_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/almph_dp.sv */
// Datapath of the peak meter: registers, channel state, shared multiplier, output register.
// Depends on almph_pkg; commanded by almph_ctrl.
module almph_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  almph_pkg::cmd_t                 cmd_i,
  output almph_pkg::status_t              st_o,
  input  logic                            cfg_valid_i,
  input  logic [almph_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_req_type_i,
  input  logic [15:0]                     in_sample_i,
  input  logic                            in_last_of_block_i,
  input  logic [31:0]                     in_time_now_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [3:0]                      out_channel_o,
  output logic [16:0]                     out_level_o,
  output logic [16:0]                     out_held_peak_o,
  output logic                            out_last_o
);
  import almph_pkg::*;

  // Configuration registers
  logic        depth_q;
  logic [4:0]  count_q;
  logic [15:0] mask_q;
  logic [31:0] coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 1'b1;
      count_q <= 5'd2;
      mask_q  <= 16'h0003;
      coeff_q <= DECAY_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_DEPTH:  depth_q <= cfg_data_i[0];
        CFG_CHANNEL_COUNT: count_q <= cfg_data_i[4:0];
        CFG_CHANNEL_MASK:  mask_q  <= cfg_data_i[15:0];
        CFG_DECAY_COEFF:   coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [4:0] cnt;
  assign cnt = (count_q == 5'd0) ? 5'd1 :
               (count_q > 5'(MaxChannels)) ? 5'(MaxChannels) : count_q;

  // Latched item
  logic        req_q, lastb_q;
  logic [15:0] smp_q;
  logic [31:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q   <= in_req_type_i;
      smp_q   <= in_sample_i;
      lastb_q <= in_last_of_block_i;
      now_q   <= in_time_now_i;
    end
  end

  // Channel state
  logic [15:0] rm_q [MaxChannels];
  logic [16:0] lf_q [MaxChannels];
  logic [16:0] hl_q [MaxChannels];
  logic [31:0] ht_q [MaxChannels];
  logic [3:0]  pos_q;
  logic [4:0]  shown_q;
  logic [4:0]  i_q, k_q, j_q;
  logic [3:0]  iter_q, n_q;
  logic [30:0] x_q;
  logic [15:0] frac_q;
  logic [63:0] mul_q, sq_q, hi_q;
  logic [31:0] dt_q;
  logic [20:0] drop_q;

  // Sample magnitude
  logic [16:0] mag16;
  logic [7:0]  b8;
  logic [8:0]  mag8;
  logic [15:0] mag;
  assign mag16 = smp_q[15] ? (17'h10000 - {1'b0, smp_q}) : {1'b0, smp_q};
  assign b8    = smp_q[7:0] ^ 8'h80;
  assign mag8  = b8[7] ? (9'h100 - {1'b0, b8}) : {1'b0, b8};
  assign mag   = depth_q ? mag16[15:0] : {7'd0, mag8};

  logic [3:0] pos_use, pos_nxt;
  logic [4:0] pos_inc;
  assign pos_use = ({1'b0, pos_q} >= cnt) ? 4'd0 : pos_q;
  assign pos_inc = {1'b0, pos_use} + 5'd1;
  assign pos_nxt = (pos_inc >= cnt) ? 4'd0 : pos_inc[3:0];

  // Log conversion front end
  logic [15:0] v;
  logic [3:0]  n_enc, fsb;
  logic [4:0]  shamt;
  logic [30:0] x_init;
  assign v   = rm_q[i_q[3:0]];
  assign fsb = depth_q ? 4'd15 : 4'd7;
  always_comb begin
    n_enc = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (v[b]) n_enc = 4'(b);
    end
  end
  assign shamt  = 5'd30 - {1'b0, n_enc};
  assign x_init = {15'd0, v} << shamt;

  logic [31:0] sq_t;
  assign sq_t = mul_q[61:30];

  logic [19:0] l2, m;
  assign l2 = {n_q, frac_q};
  assign m  = {fsb, 16'd0} - l2;

  logic [64:0] dsum;
  logic [32:0] ldrop;
  logic [16:0] lvl_calc;
  assign dsum     = {1'b0, mul_q} + 65'h80000000;
  assign ldrop    = dsum[64:32];
  assign lvl_calc = (ldrop >= 33'h10000) ? 17'd0 : (Q16_ONE - ldrop[16:0]);

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = {1'b0, x_q};
    mul_b = {1'b0, x_q};
    if (cmd_i.log_mul) begin
      mul_a = {12'd0, m};
      mul_b = LOG10_2_HALF;
    end else if (cmd_i.ref_sq) begin
      mul_a = dt_q;
      mul_b = dt_q;
    end else if (cmd_i.ref_hi) begin
      mul_a = mul_q[63:32];
      mul_b = coeff_q;
    end else if (cmd_i.ref_lo) begin
      mul_a = sq_q[31:0];
      mul_b = coeff_q;
    end
  end

  // Refresh arithmetic
  logic [3:0]  jj;
  logic [31:0] ht_eff;
  logic [32:0] dsum2;
  logic [20:0] hl21, hl_sub;
  logic        restart;
  assign jj      = j_q[3:0];
  assign ht_eff  = (ht_q[jj] == 32'd0) ? now_q : ht_q[jj];
  assign dsum2   = {13'd0, hi_q[19:0]} + {1'b0, mul_q[63:32]};
  assign hl21    = {4'd0, hl_q[jj]};
  assign hl_sub  = hl21 - drop_q;
  assign restart = (drop_q > hl21) || (hl_sub < {4'd0, lf_q[jj]});

  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mul || cmd_i.log_mul || cmd_i.ref_sq || cmd_i.ref_hi || cmd_i.ref_lo) begin
      mul_q <= mul_a * mul_b;
    end
    if (cmd_i.ref_hi) sq_q <= mul_q;
    if (cmd_i.ref_lo) hi_q <= mul_q;
    if (cmd_i.ref_fix) dt_q <= now_q - ht_eff;
    if (cmd_i.ref_drop) begin
      if (hi_q >= {43'd0, DROP_CAP}) begin
        drop_q <= DROP_CAP;
      end else if (dsum2 >= {12'd0, DROP_CAP}) begin
        drop_q <= DROP_CAP;
      end else begin
        drop_q <= dsum2[20:0];
      end
    end
    if (cmd_i.log_init) begin
      n_q    <= n_enc;
      x_q    <= x_init;
      frac_q <= 16'd0;
    end
    if (cmd_i.sq_upd) begin
      if (sq_t[31]) begin
        x_q    <= sq_t[31:1];
        frac_q <= {frac_q[14:0], 1'b1};
      end else begin
        x_q    <= sq_t[30:0];
        frac_q <= {frac_q[14:0], 1'b0};
      end
    end
    if (cmd_i.ref_out) begin
      out_channel_o   <= jj;
      out_level_o     <= lf_q[jj];
      out_held_peak_o <= restart ? lf_q[jj] : hl_sub[16:0];
      out_last_o      <= (j_q + 5'd1 == shown_q);
    end
  end

  // Zero peaks read as level 0; peaks at or above full scale saturate.
  logic lvl_direct;
  logic [16:0] lvl_dir_val;
  assign lvl_direct  = (v == 16'd0) || (n_enc >= fsb);
  assign lvl_dir_val = (v == 16'd0) ? 17'd0 : Q16_ONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxChannels; c++) begin
        rm_q[c] <= '0;
        lf_q[c] <= LEVEL_RESET;
        hl_q[c] <= '0;
        ht_q[c] <= '0;
      end
      pos_q       <= '0;
      shown_q     <= '0;
      i_q         <= '0;
      k_q         <= '0;
      j_q         <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.latch_in) j_q <= '0;
      if (cmd_i.smp_upd) begin
        if (mag > rm_q[pos_use]) rm_q[pos_use] <= mag;
        pos_q <= pos_nxt;
        i_q   <= '0;
        k_q   <= '0;
      end
      if (cmd_i.blk_skip) i_q <= i_q + 5'd1;
      if (cmd_i.log_init) begin
        iter_q <= '0;
        if (lvl_direct) begin
          lf_q[k_q[3:0]] <= lvl_dir_val;
          k_q <= k_q + 5'd1;
          i_q <= i_q + 5'd1;
        end
      end
      if (cmd_i.sq_upd) iter_q <= iter_q + 4'd1;
      if (cmd_i.log_wr) begin
        lf_q[k_q[3:0]] <= lvl_calc;
        k_q <= k_q + 5'd1;
        i_q <= i_q + 5'd1;
      end
      if (cmd_i.blk_end) begin
        shown_q <= k_q;
        pos_q   <= '0;
        for (int c = 0; c < MaxChannels; c++) rm_q[c] <= '0;
      end
      if (cmd_i.ref_fix) ht_q[jj] <= ht_eff;
      if (cmd_i.ref_out) begin
        if (restart) begin
          hl_q[jj] <= lf_q[jj];
          ht_q[jj] <= now_q;
        end
        j_q <= j_q + 5'd1;
      end
      if (cmd_i.ref_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  assign st_o.is_refresh = (req_q == REQ_REFRESH);
  assign st_o.is_last    = lastb_q;
  assign st_o.scan_end   = (i_q >= cnt);
  assign st_o.ch_shown   = mask_q[i_q[3:0]];
  assign st_o.lvl_direct = lvl_direct;
  assign st_o.iter_done  = (iter_q == 4'd15);
  assign st_o.ref_end    = (j_q >= shown_q);
  assign st_o.out_free   = out_free;

endmodule

/* rtl/audio_level_meter_peak_hold.sv */
// Audio peak meter with peak hold: takes interleaved samples and refresh requests,
// returns one level / held-peak beat per shown channel on each refresh. One item
// is worked on at a time. A sample beat is latched, then updates the running peak of
// its channel. A sample with last_of_block walks the enabled channels and, for each
// shown channel with a peak between zero and full scale, runs the log conversion
// (a setup step, 16 squarings through the one shared 32x32 multiplier, each a
// multiply then an update, then the scaling multiply and the write). A refresh
// steps each shown channel through time fix, squaring, two coefficient multiplies,
// drop and output, and waits while the sink holds ready low. Register writes are
// taken in any cycle. Depends on almph_pkg, almph_if, almph_ctrl and almph_dp.
module audio_level_meter_peak_hold (
  input  logic             clk_i,
  input  logic             rst_ni,
  almph_cfg_if.sink        cfg_i,
  almph_in_if.sink         in_i,
  almph_out_if.source      out_o
);
  import almph_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_i.ready = 1'b1;

  almph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  almph_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .cfg_valid_i        (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .in_req_type_i      (in_i.req_type),
    .in_sample_i        (in_i.sample),
    .in_last_of_block_i (in_i.last_of_block),
    .in_time_now_i      (in_i.time_now),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_channel_o      (out_o.channel),
    .out_level_o        (out_o.level),
    .out_held_peak_o    (out_o.held_peak),
    .out_last_o         (out_o.last)
  );

endmodule

/* rtl/almph_checker.sv */
// Port-level checker of the peak meter, bound to the top level.
// Depends on audio_level_meter_peak_hold_defines.svh.
`include "audio_level_meter_peak_hold_defines.svh"

module almph_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_level,
  input logic [16:0] out_held_peak,
  input logic        out_last
);

  // A stalled result beat stays and keeps its held peak.
  `ALMPH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_held_peak))

  // After an accepted item the block is busy with it.
  `ALMPH_ASSERT(a_busy_after_in, clk_i, rst_ni, in_valid && in_ready |=> !in_ready)

  // The last beat of a refresh is followed by no further result.
  `ALMPH_ASSERT(a_last_ends, clk_i, rst_ni, out_valid && out_ready && out_last |=> !out_valid)

  // Meter fractions never exceed full scale.
  `ALMPH_NEVER(a_range, clk_i, rst_ni, out_valid && (out_level > 17'h10000 || out_held_peak > 17'h10000))

endmodule

bind audio_level_meter_peak_hold almph_checker u_almph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_level     (out_o.level),
  .out_held_peak (out_o.held_peak),
  .out_last      (out_o.last)
);
